// ----- rtl/v2dt_pkg.sv -----
// ----------------------------------------------------------------------------
// v2dt_pkg
// Shared types, constants and the Q1.14 sine table for the 2D vertex transform.
// ----------------------------------------------------------------------------
package v2dt_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;

    localparam int TRIG_FRAC   = 14;
    localparam int TRIG_W      = TRIG_FRAC + 2;   // signed, holds +/-1.0
    localparam int LUT_W       = TRIG_FRAC + 1;   // unsigned table entries

    localparam int MUL_W  = (COORD_WIDTH > TRIG_W) ? COORD_WIDTH : TRIG_W;
    localparam int PROD_W = COORD_WIDTH + MUL_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int CFG_DATA_W = (COORD_WIDTH > 9) ? COORD_WIDTH : 9;
    localparam int CFG_IDX_W  = 3;
    localparam int ANGLE_W    = 9;

    localparam int TDATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] SCALE_RND =
        (FRAC_BITS > 0) ? SUM_W'(64'd1 << (FRAC_BITS - 1)) : '0;
    localparam logic signed [SUM_W-1:0] TRIG_RND = SUM_W'(64'd1 << (TRIG_FRAC - 1));

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_PASS      = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_DEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCKWISE = 3'd4;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] val;
        logic                          clip;
    } sat_t;

    // round(16384 * sin(d)), d = 0..90
    function automatic logic [LUT_W-1:0] sin_lut(input logic [6:0] d);
        logic [LUT_W-1:0] v;
        case (d)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
            7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
            7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
            7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
            7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
            7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
            7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
            7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
            7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
            7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
            7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
            7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
            7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
            7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
            7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
            7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
            7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
            7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
            7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
            7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
            7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
            7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Quadrant folding onto the 0..90 table; angles past a full turn wrap once.
    function automatic trig_t trig_lookup(input logic [ANGLE_W-1:0] ang, input logic cw);
        logic [ANGLE_W-1:0] a;
        logic [ANGLE_W-1:0] is_idx;
        logic [ANGLE_W-1:0] ic_idx;
        logic               s_neg;
        logic               c_neg;
        logic signed [TRIG_W-1:0] s_mag;
        logic signed [TRIG_W-1:0] c_mag;
        trig_t t;
        a = (ang >= 9'd360) ? ang - 9'd360 : ang;
        if (a <= 9'd90) begin
            is_idx = a;           ic_idx = 9'd90 - a;  s_neg = 1'b0; c_neg = 1'b0;
        end else if (a <= 9'd180) begin
            is_idx = 9'd180 - a;  ic_idx = a - 9'd90;  s_neg = 1'b0; c_neg = 1'b1;
        end else if (a <= 9'd270) begin
            is_idx = a - 9'd180;  ic_idx = 9'd270 - a; s_neg = 1'b1; c_neg = 1'b1;
        end else begin
            is_idx = 9'd360 - a;  ic_idx = a - 9'd270; s_neg = 1'b1; c_neg = 1'b0;
        end
        s_mag = $signed({1'b0, sin_lut(is_idx[6:0])});
        c_mag = $signed({1'b0, sin_lut(ic_idx[6:0])});
        t.s = ((s_neg ^ cw) == 1'b1) ? -s_mag : s_mag;
        t.c = c_neg ? -c_mag : c_mag;
        return t;
    endfunction

endpackage

// ----- rtl/vertex_2d_transform.sv -----
// ----------------------------------------------------------------------------
// vertex_2d_transform
// Translate, scale or rotate one signed fixed-point 2D vertex per item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_        in         s_tvalid / s_tready   s_tdata = {vy, vx}
//  m_        out        m_tvalid / m_tready   m_tdata = {ry, rx}, m_tuser = clipped
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Three register stages: input, products, result. One item is taken every
//  cycle unless the output stalls; the multiplier stage sets the clock.
//  Each stage advances when the stage after it is empty or moving, so a full
//  result register still lets earlier stages fill before s_tready drops.
//  aresetn is synchronous; it clears the stage valids and the configuration registers.
//  cfg_ready is always high; the sine/cosine register is loaded from the angle register.
// ----------------------------------------------------------------------------
module vertex_2d_transform
    import v2dt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,    // vx, vy

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,    // rx, ry
    output logic                   m_tuser,    // clipped

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    mode_t                         mode_reg;
    logic signed [COORD_WIDTH-1:0] param_x_reg;
    logic signed [COORD_WIDTH-1:0] param_y_reg;
    logic [ANGLE_W-1:0]            angle_reg;
    logic                          cw_reg;
    trig_t                         trig_reg;

    // pipeline
    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [PROD_W-1:0]      xc_reg, yc_reg, xs_reg, ys_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg;
    logic                          clip_reg;

    logic                          en1, en2, en3;
    logic signed [MUL_W-1:0]       kx, ky;
    logic signed [PROD_W-1:0]      xc_next, yc_next, xs_next, ys_next;
    logic signed [SUM_W-1:0]       nx_wide, ny_wide;
    sat_t                          rx_next, ry_next;

    assign cfg_ready = 1'b1;
    assign en3       = !v3_reg || m_tready;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign s_tready  = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_TRANSLATE;
            param_x_reg <= '0;
            param_y_reg <= '0;
            angle_reg   <= '0;
            cw_reg      <= 1'b0;
            trig_reg    <= '0;
        end else begin
            trig_reg <= trig_lookup(angle_reg, cw_reg);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE:      mode_reg    <= mode_t'(cfg_data[1:0]);
                    REG_PARAM_X:   param_x_reg <= cfg_data[COORD_WIDTH-1:0];
                    REG_PARAM_Y:   param_y_reg <= cfg_data[COORD_WIDTH-1:0];
                    REG_ANGLE_DEG: angle_reg   <= cfg_data[ANGLE_W-1:0];
                    REG_CLOCKWISE: cw_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            x1_reg <= s_tdata[COORD_WIDTH-1:0];
            y1_reg <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end
    end

    // stage 2: products; scale reuses the cosine multipliers for the factors
    always_comb begin
        if (mode_reg == MODE_ROTATE) begin
            kx = MUL_W'(trig_reg.c);
            ky = MUL_W'(trig_reg.c);
        end else begin
            kx = MUL_W'(param_x_reg);
            ky = MUL_W'(param_y_reg);
        end
        xc_next = PROD_W'(x1_reg) * PROD_W'(kx);
        yc_next = PROD_W'(y1_reg) * PROD_W'(ky);
        xs_next = PROD_W'(x1_reg) * PROD_W'(trig_reg.s);
        ys_next = PROD_W'(y1_reg) * PROD_W'(trig_reg.s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            xc_reg <= xc_next;
            yc_reg <= yc_next;
            xs_reg <= xs_next;
            ys_reg <= ys_next;
        end
    end

    // stage 3: combine, round half up (floor of biased value) in scale and rotate, saturate
    function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if ((&v[SUM_W-1:COORD_WIDTH-1]) || !(|v[SUM_W-1:COORD_WIDTH-1])) begin
            r.val  = v[COORD_WIDTH-1:0];
            r.clip = 1'b0;
        end else begin
            r.val  = v[SUM_W-1] ? COORD_MIN : COORD_MAX;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        case (mode_reg)
            MODE_TRANSLATE: begin
                nx_wide = SUM_W'(x2_reg) + SUM_W'(param_x_reg);
                ny_wide = SUM_W'(y2_reg) + SUM_W'(param_y_reg);
            end
            MODE_SCALE: begin
                nx_wide = (SUM_W'(xc_reg) + SCALE_RND) >>> FRAC_BITS;
                ny_wide = (SUM_W'(yc_reg) + SCALE_RND) >>> FRAC_BITS;
            end
            MODE_ROTATE: begin
                nx_wide = (SUM_W'(xc_reg) - SUM_W'(ys_reg) + TRIG_RND) >>> TRIG_FRAC;
                ny_wide = (SUM_W'(xs_reg) + SUM_W'(yc_reg) + TRIG_RND) >>> TRIG_FRAC;
            end
            default: begin
                nx_wide = SUM_W'(x2_reg);
                ny_wide = SUM_W'(y2_reg);
            end
        endcase
        rx_next = saturate(nx_wide);
        ry_next = saturate(ny_wide);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            rx_reg   <= rx_next.val;
            ry_reg   <= ry_next.val;
            clip_reg <= rx_next.clip | ry_next.clip;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = TDATA_W'({ry_reg, rx_reg});
    assign m_tuser  = clip_reg;

    // ------------------------------------------------------------------------
    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (rx_reg == COORD_MAX || rx_reg == COORD_MIN ||
                                   ry_reg == COORD_MAX || ry_reg == COORD_MIN))
        else $error("clipped item without a saturated coordinate");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled while the pipeline has room");

    a_mid_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !en3) |=> (v2_reg && $stable(xc_reg) && $stable(ys_reg)))
        else $error("product stage changed while stalled");

endmodule
